>>> rtl/core/sam_pkg.sv
// Shared widths, codes and item types of the sensor alarm monitor.
package sam_pkg;

  localparam int SAMPLE_BITS = 16;

  localparam int W_W    = SAMPLE_BITS + 4;
  localparam int OP_W   = SAMPLE_BITS + 3;
  localparam int OP_D   = (OP_W + 1) / 2;
  localparam int SUM_W  = 2 * OP_W;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int MAG_W  = ROOT_W + 1;
  localparam int CMP_W  = (MAG_W > 20) ? MAG_W : 20;
  localparam int VS_W   = (OP_W + 2 > 21) ? OP_W + 2 : 21;
  localparam int RZ_W   = (SAMPLE_BITS + 1 > 17) ? SAMPLE_BITS + 1 : 17;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUMIDITY_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT     = 2'd3;

  localparam logic signed [7:0] TEMP_LIMIT_RST     = 8'sd38;
  localparam logic [6:0]        HUMIDITY_LIMIT_RST = 7'd80;
  localparam logic [19:0]       ACCEL_LIMIT_RST    = 20'd130;
  localparam logic [15:0]       RATE_LIMIT_RST     = 16'd800;

  localparam logic [19:0] MAG_MAX = 20'hFFFFF;

  localparam logic ITEM_STATUS = 1'b0;
  localparam logic ITEM_REPORT = 1'b1;

  localparam logic [1:0] ALM_HEAT      = 2'd0;
  localparam logic [1:0] ALM_FLOOD     = 2'd1;
  localparam logic [1:0] ALM_COLLISION = 2'd2;
  localparam logic [1:0] ALM_OVERTURN  = 2'd3;

  typedef struct packed {
    logic signed [7:0]             temperature;
    logic [6:0]                    humidity;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    logic signed [SAMPLE_BITS-1:0] rate_x;
    logic signed [SAMPLE_BITS-1:0] rate_y;
    logic signed [SAMPLE_BITS-1:0] rate_z;
  } sam_in_t;

  typedef struct packed {
    logic              item_kind;
    logic [3:0]        alarm_flags;
    logic              recovered;
    logic [19:0]       magnitude;
    logic [1:0]        alarm_kind;
    logic signed [7:0] scalar_value;
    logic signed [19:0] vector_x;
    logic signed [19:0] vector_y;
    logic signed [19:0] vector_z;
    logic              last_item;
  } sam_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WEIGH,
    ST_LOAD,
    ST_SQUARE,
    ST_SUM_XY,
    ST_SUM_Z,
    ST_ROOT_GO,
    ST_ROOT,
    ST_ROUND,
    ST_FLAGS,
    ST_EMIT
  } sam_state_t;

endpackage

>>> rtl/core/sensor_alarm_monitor_unit.sv
// Three digit-serial squarers (two bits a cycle) and a root unit (one bit a cycle) do the math.
// A new sample is not accepted (in_stall high) until all items of the previous one are out.
// Reports follow the status item on consecutive cycles while out_stall is low, one per set
// flag, only while the alarm latch is clear (set on reported alarms, cleared on recovery).
// Reset (rst_n low, synchronous): idle, limits to defaults, previous flags and latch cleared.
module sensor_alarm_monitor_unit import sam_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sam_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sam_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  sam_state_t state_r, state_nxt;

  sam_in_t                 in_r;
  logic signed [W_W-1:0]   wx_r, wy_r, wz_r;
  logic signed [W_W-1:0]   ax_e, ay_e, az_e;
  logic signed [W_W-1:0]   wx_c, wy_c, wz_c;
  logic [OP_W-1:0]         absx_c, absy_c, absz_c;
  logic [OP_W-1:0]         absx_r, absy_r, absz_r;
  logic                    heat_r, flood_r, ovt_r;
  logic                    heat_c, flood_c, ovt_c;
  logic signed [RZ_W-1:0]  rz_e;
  logic [RZ_W-1:0]         rz_mag;
  logic [SUM_W-1:0]        s_r;
  logic [MAG_W-1:0]        mag_r;
  logic [CMP_W-1:0]        mag_e;
  logic [19:0]             mag_out;
  logic                    coll_c;
  logic [3:0]              flags_c;
  logic [3:0]              pend_c;
  logic                    recov_c;
  logic [3:0]              prev_r;
  logic                    latch_r;
  logic [3:0]              pend_r;
  logic [1:0]              kind_c;
  logic [3:0]              bit_c;
  sam_out_t                out_r;
  sam_out_t                status_c;
  sam_out_t                rep_c;

  logic signed [7:0]       temp_lim_r;
  logic [6:0]              hum_lim_r;
  logic [19:0]             acc_lim_r;
  logic [15:0]             rate_lim_r;

  logic                    sq_start, rt_start;
  logic                    dx, dy, dz, rt_done;
  logic [SUM_W-1:0]        sqx, sqy, sqz;
  logic [MAG_W-1:0]        rt_mag;

  localparam logic signed [VS_W-1:0] VS_MAX = VS_W'(524287);
  localparam logic signed [VS_W-1:0] VS_MIN = VS_W'(-524288);

  function automatic logic signed [19:0] sat_vec(input logic signed [VS_W-1:0] v);
    return (v > VS_MAX) ? VS_MAX[19:0] : ((v < VS_MIN) ? VS_MIN[19:0] : v[19:0]);
  endfunction

  sam_sqr u_sqr_x (.clk, .rst_n, .start(sq_start), .operand(absx_c), .done(dx), .square(sqx));
  sam_sqr u_sqr_y (.clk, .rst_n, .start(sq_start), .operand(absy_c), .done(dy), .square(sqy));
  sam_sqr u_sqr_z (.clk, .rst_n, .start(sq_start), .operand(absz_c), .done(dz), .square(sqz));

  sam_root u_root (
    .clk, .rst_n, .start(rt_start), .radicand(s_r), .done(rt_done), .mag(rt_mag)
  );

  // weighted cross product with (4,5,6)
  assign ax_e = W_W'(in_r.accel_x);
  assign ay_e = W_W'(in_r.accel_y);
  assign az_e = W_W'(in_r.accel_z);
  assign wx_c = (ay_e <<< 2) + (ay_e <<< 1) - (az_e <<< 2) - az_e;
  assign wy_c = (az_e <<< 2) - (ax_e <<< 2) - (ax_e <<< 1);
  assign wz_c = (ax_e <<< 2) + ax_e - (ay_e <<< 2);

  assign absx_c = wx_r[W_W-1] ? OP_W'(-wx_r) : OP_W'(wx_r);
  assign absy_c = wy_r[W_W-1] ? OP_W'(-wy_r) : OP_W'(wy_r);
  assign absz_c = wz_r[W_W-1] ? OP_W'(-wz_r) : OP_W'(wz_r);

  assign heat_c  = in_r.temperature > temp_lim_r;
  assign flood_c = in_r.humidity > hum_lim_r;
  assign rz_e    = RZ_W'(in_r.rate_z);
  assign rz_mag  = RZ_W'(-rz_e);
  assign ovt_c   = in_r.rate_z[SAMPLE_BITS-1] && (rz_mag >= RZ_W'(rate_lim_r));

  assign mag_e   = CMP_W'(mag_r);
  assign coll_c  = mag_e > CMP_W'(acc_lim_r);
  assign mag_out = (mag_e > CMP_W'(MAG_MAX)) ? MAG_MAX : mag_e[19:0];

  assign flags_c = {ovt_r, coll_c, flood_r, heat_r};
  assign recov_c = (prev_r != 4'd0) && (flags_c == 4'd0);
  assign pend_c  = ((flags_c != 4'd0) && !latch_r) ? flags_c : 4'd0;

  always_comb begin
    status_c              = '0;
    status_c.item_kind    = ITEM_STATUS;
    status_c.alarm_flags  = flags_c;
    status_c.recovered    = recov_c;
    status_c.magnitude    = mag_out;
    status_c.last_item    = (pend_c == 4'd0);
  end

  always_comb begin
    if (pend_r[0]) begin
      kind_c = ALM_HEAT;
    end else if (pend_r[1]) begin
      kind_c = ALM_FLOOD;
    end else if (pend_r[2]) begin
      kind_c = ALM_COLLISION;
    end else begin
      kind_c = ALM_OVERTURN;
    end
    bit_c = 4'd1 << kind_c;
  end

  always_comb begin
    rep_c             = '0;
    rep_c.item_kind   = ITEM_REPORT;
    rep_c.alarm_flags = bit_c;
    rep_c.magnitude   = mag_out;
    rep_c.alarm_kind  = kind_c;
    rep_c.last_item   = ((pend_r & ~bit_c) == 4'd0);
    case (kind_c)
      ALM_HEAT:  rep_c.scalar_value = in_r.temperature;
      ALM_FLOOD: rep_c.scalar_value = {1'b0, in_r.humidity};
      ALM_COLLISION: begin
        rep_c.vector_x = sat_vec(VS_W'({1'b0, absx_r}));
        rep_c.vector_y = sat_vec(VS_W'({1'b0, absy_r}));
        rep_c.vector_z = sat_vec(VS_W'({1'b0, absz_r}));
      end
      default: begin
        rep_c.vector_x = sat_vec(VS_W'(in_r.rate_x));
        rep_c.vector_y = sat_vec(VS_W'(in_r.rate_y));
        rep_c.vector_z = sat_vec(VS_W'(in_r.rate_z));
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_WEIGH;
      ST_WEIGH:   state_nxt = ST_LOAD;
      ST_LOAD:    state_nxt = ST_SQUARE;
      ST_SQUARE:  if (dx && dy && dz) state_nxt = ST_SUM_XY;
      ST_SUM_XY:  state_nxt = ST_SUM_Z;
      ST_SUM_Z:   state_nxt = ST_ROOT_GO;
      ST_ROOT_GO: state_nxt = ST_ROOT;
      ST_ROOT:    if (rt_done) state_nxt = ST_ROUND;
      ST_ROUND:   state_nxt = ST_FLAGS;
      ST_FLAGS:   state_nxt = ST_EMIT;
      ST_EMIT:    if (!out_stall && pend_r == 4'd0) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    out_valid = (state_r == ST_EMIT);
    sq_start  = (state_r == ST_LOAD);
    rt_start  = (state_r == ST_ROOT_GO);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      prev_r     <= 4'd0;
      latch_r    <= 1'b0;
      pend_r     <= 4'd0;
      temp_lim_r <= TEMP_LIMIT_RST;
      hum_lim_r  <= HUMIDITY_LIMIT_RST;
      acc_lim_r  <= ACCEL_LIMIT_RST;
      rate_lim_r <= RATE_LIMIT_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FLAGS) begin
        prev_r <= flags_c;
        pend_r <= pend_c;
        if (recov_c) begin
          latch_r <= 1'b0;
        end else if (pend_c != 4'd0) begin
          latch_r <= 1'b1;
        end
      end else if (state_r == ST_EMIT && !out_stall) begin
        pend_r <= pend_r & ~bit_c;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_TEMP_LIMIT:     temp_lim_r <= cfg_data[7:0];
          REG_HUMIDITY_LIMIT: hum_lim_r  <= cfg_data[6:0];
          REG_ACCEL_LIMIT:    acc_lim_r  <= cfg_data[19:0];
          REG_RATE_LIMIT:     rate_lim_r <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      in_r <= in_data;
    end
    if (state_r == ST_WEIGH) begin
      wx_r    <= wx_c;
      wy_r    <= wy_c;
      wz_r    <= wz_c;
      heat_r  <= heat_c;
      flood_r <= flood_c;
      ovt_r   <= ovt_c;
    end
    if (state_r == ST_LOAD) begin
      absx_r <= absx_c;
      absy_r <= absy_c;
      absz_r <= absz_c;
    end
    if (state_r == ST_SUM_XY) begin
      s_r <= sqx + sqy;
    end else if (state_r == ST_SUM_Z) begin
      s_r <= s_r + sqz;
    end
    if (state_r == ST_ROUND) begin
      mag_r <= rt_mag;
    end
    if (state_r == ST_FLAGS) begin
      out_r <= status_c;
    end else if (state_r == ST_EMIT && !out_stall && pend_r != 4'd0) begin
      out_r <= rep_c;
    end
  end

  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

endmodule

>>> rtl/core/sam_sqr.sv
// Digit-serial squarer, two multiplier bits per cycle, most significant first.
module sam_sqr import sam_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [OP_W-1:0]   operand,
  output logic              done,
  output logic [SUM_W-1:0]  square
);

  localparam int PW    = 2 * OP_D;
  localparam int AW    = 2 * PW;
  localparam int CNT_W = $clog2(OP_D + 1);

  logic [OP_W+1:0]  m1_r;
  logic [OP_W+1:0]  m3_r;
  logic [PW-1:0]    mp_r;
  logic [AW-1:0]    acc_r;
  logic [AW-1:0]    sel;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  always_comb begin
    case (mp_r[PW-1 -: 2])
      2'd0:    sel = '0;
      2'd1:    sel = AW'(m1_r);
      2'd2:    sel = AW'(m1_r) << 1;
      default: sel = AW'(m3_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(OP_D);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m1_r  <= (OP_W + 2)'(operand);
      m3_r  <= ((OP_W + 2)'(operand) << 1) + (OP_W + 2)'(operand);
      mp_r  <= PW'(operand);
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= (acc_r << 2) + sel;
      mp_r  <= mp_r << 2;
    end
  end

  assign done   = done_r;
  assign square = acc_r[SUM_W-1:0];

endmodule

>>> rtl/core/sam_root.sv
// Digit-serial integer square root, one result bit per cycle, rounded to nearest.
module sam_root import sam_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  radicand,
  output logic              done,
  output logic [MAG_W-1:0]  mag
);

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [SUM_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W+1:0]  cur;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              ge;

  assign cur   = {rem_r, rad_r[SUM_W-1 -: 2]};
  assign trial = (REM_W + 2)'({root_r, 2'b01});
  assign diff  = cur - trial;
  assign ge    = (cur >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(ROOT_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= rad_r << 2;
      if (ge) begin
        rem_r  <= diff[REM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= cur[REM_W-1:0];
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign mag  = MAG_W'(root_r) + MAG_W'(rem_r > REM_W'(root_r));

endmodule

>>> rtl/core/sam_checker.sv
// Port-level checks of the sensor alarm monitor, bound to the top level.
module sam_checker import sam_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input sam_out_t out_data
);

  a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while results pending");

  a_status_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == ITEM_STATUS && !out_data.last_item
      |-> out_data.alarm_flags != 4'd0 && !out_data.recovered)
    else $error("status item announces reports without flags");

  a_report_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == ITEM_REPORT
      |-> $onehot(out_data.alarm_flags) && !out_data.recovered)
    else $error("report item with bad flag field");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

endmodule

bind sensor_alarm_monitor_unit sam_checker u_sam_checker (.*);
